// File: rtl/core/oaid_pkg.sv
// Shared types and constants for the ordered array insert/delete block.
// No dependencies; compile first.
`timescale 1ns / 1ps

package oaid_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = 5;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd10;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_APPEND = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } st_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;  // capture the incoming word
    logic exec;  // run the operation, update list, load result register
  } cmd_t;

endpackage

// File: rtl/core/oaid_if.sv
// Valid/ready channel interfaces for request and result words.
// Depends on oaid_pkg.
`timescale 1ns / 1ps

interface oaid_req_if import oaid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] item_value;

  modport source (output valid, output opcode, output position, output item_value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input item_value,
                  output ready);
endinterface

interface oaid_rsp_if import oaid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] data_out;
  logic [ST_W-1:0]          status;
  logic [CNT_W-1:0]         count_after;

  modport source (output valid, output data_out, output status, output count_after,
                  input ready);
  modport sink   (input valid, input data_out, input status, input count_after,
                  output ready);
endinterface

// File: rtl/core/oaid_ctrl.sv
// Controller FSM: request handshake, execute strobe, result valid flag.
// Depends on oaid_pkg.
`timescale 1ns / 1ps

module oaid_ctrl import oaid_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // result register can take a new word this cycle
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.exec = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.exec) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/oaid_dp.sv
// Datapath: entry register file with parallel shift, count, limit, result register.
// Depends on oaid_pkg.
`timescale 1ns / 1ps

module oaid_dp import oaid_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  input  logic [OP_W-1:0]          opcode,
  input  logic [POS_W-1:0]         position,
  input  logic signed [WORD_W-1:0] item_value,
  input  logic                     cfg_we,
  input  logic [CNT_W-1:0]         cfg_wdata,
  output logic signed [WORD_W-1:0] data_out,
  output logic [ST_W-1:0]          status,
  output logic [CNT_W-1:0]         count_after
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = $clog2(DEPTH + 1);
  localparam int CW    = (DW > CNT_W) ? DW : CNT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  op_t                     op_r;
  logic [POS_W-1:0]        pos_r;
  logic signed [WORD_W-1:0] val_r;
  logic [CNT_W-1:0]        cap_r;
  // count is wide enough for the full depth; the result field wraps
  logic [CW-1:0]           count_r, count_nxt;
  logic signed [WORD_W-1:0] entries_r [DEPTH];
  logic signed [WORD_W-1:0] data_out_r;
  st_t                     status_r;
  logic [CNT_W-1:0]        count_after_r;

  logic [CW-1:0]           cnt_ext, pos_ext, cap_ext, limit;
  logic                    full, rd_ok;
  logic signed [WORD_W-1:0] rd_word;
  logic                    do_ins, do_del;
  logic [CW-1:0]           ins_pos;
  st_t                     st_c;
  logic signed [WORD_W-1:0] data_c;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(opcode);
      pos_r <= position;
      val_r <= item_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CAP_RESET;
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  assign cnt_ext = count_r;
  assign pos_ext = CW'(pos_r);
  assign cap_ext = CW'(cap_r);
  assign limit   = (cap_ext < DEPTH_C) ? cap_ext : DEPTH_C;
  assign full    = cnt_ext >= limit;
  assign rd_ok   = pos_ext < cnt_ext;
  assign rd_word = entries_r[AW'(pos_r)];

  always_comb begin
    st_c    = ST_OK;
    data_c  = '0;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    ins_pos = pos_ext;
    case (op_r)
      OP_READ: begin
        if (!rd_ok) st_c = ST_RANGE;
        else data_c = rd_word;
      end
      OP_APPEND: begin
        ins_pos = cnt_ext;
        if (full) st_c = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_INSERT: begin
        if (pos_ext > cnt_ext) st_c = ST_RANGE;
        else if (full) st_c = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_DELETE: begin
        if (!rd_ok) st_c = ST_RANGE;
        else begin
          data_c = rd_word;
          do_del = 1'b1;
        end
      end
      default: st_c = ST_OK;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) count_nxt = count_r + CW'(1);
    else if (do_del) count_nxt = count_r - CW'(1);
  end

  // each entry picks its own next value: hold, new word, lower or upper neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    localparam logic [CW-1:0] IDX = CW'(i);
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (cmd.exec) begin
          if (do_ins && IDX == ins_pos) entries_r[i] <= val_r;
          else if (do_del && IDX >= pos_ext && IDX + CW'(1) < cnt_ext)
            entries_r[i] <= entries_r[i+1];
        end
      end
    end else if (i == DEPTH - 1) begin : g_last
      always_ff @(posedge clk) begin
        if (cmd.exec) begin
          if (do_ins && IDX == ins_pos) entries_r[i] <= val_r;
          else if (do_ins && IDX > ins_pos && IDX <= cnt_ext)
            entries_r[i] <= entries_r[i-1];
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.exec) begin
          if (do_ins && IDX == ins_pos) entries_r[i] <= val_r;
          else if (do_ins && IDX > ins_pos && IDX <= cnt_ext)
            entries_r[i] <= entries_r[i-1];
          else if (do_del && IDX >= pos_ext && IDX + CW'(1) < cnt_ext)
            entries_r[i] <= entries_r[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (cmd.exec) count_r <= count_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      data_out_r    <= data_c;
      status_r      <= st_c;
      count_after_r <= CNT_W'(count_nxt);
    end
  end

  assign data_out    = data_out_r;
  assign status      = status_r;
  assign count_after = count_after_r;

endmodule

// File: rtl/core/ordered_array_insert_delete_top.sv
// Top level of the ordered array insert/delete block.
// Depends on oaid_pkg, oaid_if, oaid_ctrl, oaid_dp.
//
// Usage:
//   in_ch  : request words {opcode, position, item_value}, valid/ready.
//            opcode 0 read, 1 append, 2 insert, 3 delete.
//   out_ch : one result word per request {data_out, status, count_after},
//            valid/ready. status 0 ok, 1 full, 2 index out of range.
//   cfg_we/cfg_wdata : capacity limit register (reset 10); effective
//            limit is min(capacity, DEPTH). Write only while idle.
// Timing:
//   A request is accepted when in_ch.valid && in_ch.ready. In the execute
//   state, once the result register is free, the whole list shifts in
//   parallel and the result register loads, and the result shows on out_ch.
//   One request is in flight at a time: the FSM accepts a request in the
//   idle state and executes it in the execute state before it takes another.
//   If out_ch stalls, the next request is still accepted; it then waits in
//   the execute state until the result register drains.
// Reset (rst_n, sync, active low): list empty, capacity back to 10, no
//   result pending. Entry contents are not cleared; unused slots are never
//   read.
`timescale 1ns / 1ps

module ordered_array_insert_delete_top import oaid_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  oaid_req_if.sink          in_ch,
  oaid_rsp_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata
);

  cmd_t cmd;

  oaid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  oaid_dp #(.DEPTH(DEPTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .opcode      (in_ch.opcode),
    .position    (in_ch.position),
    .item_value  (in_ch.item_value),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .data_out    (out_ch.data_out),
    .status      (out_ch.status),
    .count_after (out_ch.count_after)
  );

endmodule

// File: rtl/core/oaid_chk.sv
// Port-level checker for the ordered array insert/delete top, bound to it.
// Depends on oaid_pkg and ordered_array_insert_delete_top.
`timescale 1ns / 1ps

module oaid_chk import oaid_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [WORD_W-1:0] data_out,
  input logic [ST_W-1:0]          status
);

  // no result may survive reset
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one request in flight: ready drops right after acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while one is executing");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_RANGE))
    else $error("undefined status code");

  // failed operations return zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> data_out == '0)
    else $error("nonzero data on failed operation");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(status))
    else $error("result changed while stalled");

endmodule

bind ordered_array_insert_delete_top oaid_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .data_out  (out_ch.data_out),
  .status    (out_ch.status)
);

// File: tb/tb_ordered_array_insert_delete_top.sv
// Self-checking testbench for the ordered array insert/delete block.
// Depends on oaid_pkg, oaid_if and ordered_array_insert_delete_top.
`timescale 1ns / 1ps

module tb_ordered_array_insert_delete_top;
  import oaid_pkg::*;

  localparam int LIST_DEPTH    = 16;
  localparam int CYCLE_LIMIT   = 500000;
  // Settle margin after the last expected result word has drained, before
  // a capacity write or the end of the run.
  localparam int SETTLE_CYCLES = 4;

  // One expected result word.
  typedef struct {
    logic signed [WORD_W-1:0] data;
    st_t                      status;
    logic [CNT_W-1:0]         count;
  } list_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  oaid_req_if in_if ();
  oaid_rsp_if out_if ();

  ordered_array_insert_delete_top #(.DEPTH(LIST_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the list. Updated when a request word is accepted, so
  // its order always matches the order in which the block sees words.
  // ---------------------------------------------------------------------
  logic signed [WORD_W-1:0] shadow_list [LIST_DEPTH];
  int                       shadow_len;
  logic [CNT_W-1:0]         shadow_cap;
  list_result_t             pending_results [$];

  bit no_idle      = 1'b0;  // set for stretches with no gaps on either side
  int stall_left   = 0;
  int cycle_count  = 0;
  int fail_count   = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int cap_settings = 0;
  int status_seen [3] = '{0, 0, 0};

  // Effective limit: the capacity setting saturates at the physical depth.
  function automatic int list_limit();
    return (shadow_cap < LIST_DEPTH) ? int'(shadow_cap) : LIST_DEPTH;
  endfunction

  // Apply one operation to the shadow list and return the result word.
  // Index check comes before the full check for insert.
  function automatic list_result_t list_apply(input op_t op,
                                              input logic [POS_W-1:0] pos,
                                              input logic signed [WORD_W-1:0] val);
    list_result_t r;
    int           i;
    r.data   = '0;
    r.status = ST_OK;
    case (op)
      OP_READ: begin
        if (pos >= shadow_len) r.status = ST_RANGE;
        else r.data = shadow_list[pos];
      end
      OP_APPEND: begin
        if (shadow_len >= list_limit()) begin
          r.status = ST_FULL;
        end else begin
          shadow_list[shadow_len] = val;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        if (pos > shadow_len) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= list_limit()) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = val;
          shadow_len++;
        end
      end
      default: begin  // delete
        if (pos >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          r.data = shadow_list[pos];
          for (i = int'(pos); i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
    endcase
    r.count = shadow_len[CNT_W-1:0];
    return r;
  endfunction

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Send one request word. valid stays high on return so that a following
  // call with no gap keeps the stream back to back; callers that stop
  // sending go through wait_idle, which drops it.
  task automatic send_word(input op_t op, input logic [POS_W-1:0] pos,
                           input logic [WORD_W-1:0] val);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.position   <= pos;
    in_if.item_value <= val;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_results.push_back(list_apply(op, pos, val));
    words_sent++;
  endtask

  // Stop sending and wait until every expected result word has come back.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Capacity writes only happen with the block idle.
  task automatic write_capacity(input logic [CNT_W-1:0] cap);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we     <= 1'b0;
    shadow_cap  = cap;
    cap_settings++;
  endtask

  // ---------------------------------------------------------------------
  // Result side: compare each accepted word with the oldest expectation,
  // then pick ready for the next cycle (random stalls, short and long).
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    list_result_t exp_r;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result word: data_out=%0d status=%0d count_after=%0d",
               out_if.data_out, out_if.status, out_if.count_after);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        status_seen[exp_r.status]++;
        if (out_if.data_out !== exp_r.data) begin
          $error("data_out: expected %0d, got %0d", exp_r.data, out_if.data_out);
          fail_count++;
        end
        if (out_if.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_if.status);
          fail_count++;
        end
        if (out_if.count_after !== exp_r.count) begin
          $error("count_after: expected %0d, got %0d", exp_r.count, out_if.count_after);
          fail_count++;
        end
      end
    end
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0)
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                : $urandom_range(4, 24);
    end
  end

  // Watchdog: generous bound on the whole run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset capacity (10): empty list, ends, middle, field extremes, full,
  // and index error taking priority over full on insert.
  task automatic test_directed_ops();
    int k;
    send_word(OP_READ,   5'd0,  32'd0);          // read on empty list
    send_word(OP_DELETE, 5'd0,  32'd0);          // delete on empty list
    send_word(OP_INSERT, 5'd1,  32'd5);          // insert past the end
    send_word(OP_INSERT, 5'd0,  32'h7FFF_FFFF);  // insert at end of empty list
    send_word(OP_APPEND, 5'd31, 32'h8000_0000);  // append ignores position
    send_word(OP_INSERT, 5'd1,  32'hFFFF_FFFF);  // insert in the middle
    send_word(OP_INSERT, 5'd3,  32'd0);          // insert at position == count
    for (k = 0; k < 4; k++) send_word(OP_READ, k[POS_W-1:0], 32'hDEAD_BEEF);
    send_word(OP_READ,   5'd31, 32'd0);          // far past the end
    send_word(OP_READ,   5'd4,  32'd0);          // one past the end
    send_word(OP_DELETE, 5'd3,  32'd0);          // delete last
    send_word(OP_DELETE, 5'd3,  32'd0);          // delete at position == count
    send_word(OP_DELETE, 5'd0,  32'd0);          // delete first
    while (shadow_len < list_limit()) send_word(OP_APPEND, 5'd0, $urandom);
    send_word(OP_APPEND, 5'd0,  32'd1);          // full
    send_word(OP_INSERT, 5'd0,  32'd2);          // full
    send_word(OP_INSERT, 5'd10, 32'd3);          // full, index in range
    send_word(OP_INSERT, 5'd11, 32'd4);          // range wins over full
  endtask

  // Capacity below the count held, capacity zero, capacity above depth.
  task automatic test_capacity_limits();
    write_capacity(5'd3);                        // list holds 10 > 3
    send_word(OP_APPEND, 5'd0, 32'd11);
    send_word(OP_INSERT, 5'd4, 32'd12);
    send_word(OP_READ,   5'd9, 32'd0);           // old entries still readable
    while (shadow_len > 2) send_word(OP_DELETE, 5'd0, 32'd0);
    send_word(OP_APPEND, 5'd0, 32'h1234_5678);   // room again
    send_word(OP_APPEND, 5'd0, 32'd13);          // full at 3
    write_capacity(5'd0);
    send_word(OP_INSERT, 5'd0, 32'd14);
    send_word(OP_APPEND, 5'd0, 32'd15);
    send_word(OP_DELETE, 5'd1, 32'd0);
    send_word(OP_READ,   5'd0, 32'd0);
    send_word(OP_DELETE, 5'd0, 32'd0);
    send_word(OP_DELETE, 5'd0, 32'd0);
    send_word(OP_READ,   5'd0, 32'd0);
    write_capacity(5'd31);                       // saturates at depth
    while (shadow_len < LIST_DEPTH) send_word(OP_APPEND, 5'd0, $urandom);
    send_word(OP_APPEND, 5'd0, 32'd16);
    send_word(OP_INSERT, 5'd16, 32'd17);
    send_word(OP_READ,   5'd15, 32'd0);
    send_word(OP_READ,   5'd16, 32'd0);
  endtask

  // Random traffic over several capacity settings. The list length is
  // steered toward a moving target so that empty, full and everything in
  // between get visited; most positions are in range.
  task automatic test_random_ops();
    logic [CNT_W-1:0]  caps [6];
    int                phase_len [6];
    int                target, lim, r, p, n;
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] val;
    caps      = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd7, 5'd10};
    caps[5]   = CNT_W'($urandom_range(2, 30));
    phase_len = '{350, 200, 400, 100, 300, 350};
    target    = 0;
    for (p = 0; p < 6; p++) begin
      write_capacity(caps[p]);
      for (n = 0; n < phase_len[p]; n++) begin
        no_idle = (n >= 60 && n < 120);
        if (p == 1 && n == 100) wait_idle();  // sender holds off until drained
        if (n % 40 == 0) begin
          lim    = list_limit();
          target = ($urandom_range(0, 2) == 0) ? lim : $urandom_range(0, lim);
        end
        r = $urandom_range(0, 99);
        if (shadow_len < target)
          op = (r < 30) ? OP_APPEND : (r < 65) ? OP_INSERT : (r < 80) ? OP_READ : OP_DELETE;
        else
          op = (r < 10) ? OP_APPEND : (r < 25) ? OP_INSERT : (r < 55) ? OP_READ : OP_DELETE;
        pos = POS_W'($urandom_range(0, 31));
        if ($urandom_range(0, 99) < 85) begin
          if (op == OP_INSERT) pos = POS_W'($urandom_range(0, shadow_len));
          else if (op != OP_APPEND && shadow_len > 0)
            pos = POS_W'($urandom_range(0, shadow_len - 1));
        end
        case ($urandom_range(0, 19))
          0:       val = 32'h7FFF_FFFF;
          1:       val = 32'h8000_0000;
          2:       val = 32'h0000_0000;
          3:       val = 32'hFFFF_FFFF;
          default: val = $urandom;
        endcase
        send_word(op, pos, val);
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.opcode     = '0;
    in_if.position   = '0;
    in_if.item_value = '0;
    out_if.ready     = 1'b0;
    shadow_len       = 0;
    shadow_cap       = CAP_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_ops();
    test_capacity_limits();
    test_random_ops();

    wait_idle();
    repeat (8) @(posedge clk);

    $display("Run covered %0d request words and %0d result words over %0d capacity writes.",
             words_sent, results_seen, cap_settings);
    $display("Result status mix: ok %0d, full %0d, index out of range %0d.",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_RANGE]);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/oaid_pkg.sv
rtl/core/oaid_if.sv
rtl/core/oaid_ctrl.sv
rtl/core/oaid_dp.sv
rtl/core/ordered_array_insert_delete_top.sv
rtl/core/oaid_chk.sv
tb/tb_ordered_array_insert_delete_top.sv
